// File: sv/rpn_alu_pkg.sv
// shared constants for the rpn stack calculator: operation and status codes, sizes
package rpn_alu_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 5;

  // input word: push_value only, kind travels in tuser
  localparam int unsigned IN_DATA_W  = 32;
  // result word: status, top_value, top_valid, depth, padded to whole bytes
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ONE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

endpackage

// File: sv/rpn_stack_alu_core.sv
// rpn operand stack with saturating q16.16 add and multiply, one word per cycle while s_tready is high
//
//  channel | dir | tdata (lsb up)                                    | tuser
//  --------+-----+---------------------------------------------------+-----------
//  s_*     | in  | push_value[31:0]                                  | kind[2:0]
//  m_*     | out | status[2:0] top_value[34:3] top_valid[35]          | -
//          |     | depth[40:36] zero[47:41]                          |
//
//  one word is accepted per cycle; its result is registered, held in the skid
//  slot on a stall. the top two entries live in registers, the rest in a memory
//  whose read port is kept pointed at the third entry, so pop, add and multiply
//  never wait on the memory. a two-word output buffer lets a word be accepted
//  while one result waits; s_tready drops only when both slots are full.
//  rst clears the depth and the output buffer; the memory needs no clearing.
module rpn_stack_alu_core #(
  parameter int unsigned STACK_DEPTH = rpn_alu_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [rpn_alu_pkg::IN_DATA_W-1:0] s_tdata,   // push_value[31:0]
  input  logic [rpn_alu_pkg::KIND_W-1:0]    s_tuser,   // kind[2:0]
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status[2:0], top_value[34:3], top_valid[35], depth[40:36], zero pad [47:41]
  output logic [rpn_alu_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);  // count width
  localparam int unsigned AW = $clog2(STACK_DEPTH);      // memory address width
  localparam int unsigned VW = rpn_alu_pkg::VALUE_W;
  localparam int unsigned OW = rpn_alu_pkg::OUT_DATA_W;

  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);
  localparam logic [CW-1:0] CNT_TWO  = CW'(2);
  localparam logic [CW-1:0] CNT_THR  = CW'(3);

  // stack state
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic signed [VW-1:0] top;
  logic signed [VW-1:0] top_next;
  logic signed [VW-1:0] second;
  logic signed [VW-1:0] second_next;
  logic signed [VW-1:0] below;          // memory entry at count-3
  logic signed [VW-1:0] mem [STACK_DEPTH];

  logic          accept;
  logic          mem_we;
  logic [CW-1:0] wr_cnt;
  logic [CW-1:0] rd_cnt;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  logic [rpn_alu_pkg::KIND_W-1:0]   kind;
  logic [rpn_alu_pkg::STATUS_W-1:0] status;

  // arithmetic unit
  logic signed [VW:0]     sum;
  logic signed [VW-1:0]   sum_sat;
  logic signed [2*VW-1:0] prod;
  logic signed [VW-1:0]   prod_sat;

  // result word and output buffer
  logic [CW+4:0]                    count_ext;
  logic signed [VW-1:0]             res_top;
  logic [OW-1:0]                    res_word;
  logic                             out_valid;
  logic [OW-1:0]                    out_word;
  logic                             skid_valid;
  logic [OW-1:0]                    skid_word;

  assign kind     = s_tuser;
  assign s_tready = ~skid_valid;
  assign accept   = s_tvalid & s_tready;

  // add saturates when the carry disagrees with the sign
  assign sum     = {top[VW-1], top} + {second[VW-1], second};
  assign sum_sat = (sum[VW] != sum[VW-1]) ?
                   (sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}}) :
                   sum[VW-1:0];

  // second * top, arithmetic shift by 16 floors toward minus infinity
  assign prod     = second * top;
  assign prod_sat = (prod[2*VW-1:VW+15] != {(VW-15){prod[2*VW-1]}}) ?
                    (prod[2*VW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}}) :
                    prod[VW+15:16];

  always_comb begin
    status      = rpn_alu_pkg::ST_OK;
    count_next  = count;
    top_next    = top;
    second_next = second;
    mem_we      = 1'b0;
    if (accept) begin
      case (kind)
        rpn_alu_pkg::KIND_PUSH: begin
          if (count == CNT_FULL) begin
            status = rpn_alu_pkg::ST_FULL;
          end else begin
            top_next    = $signed(s_tdata[VW-1:0]);
            second_next = top;
            count_next  = count + CNT_ONE;
            mem_we      = (count >= CNT_TWO);
          end
        end
        rpn_alu_pkg::KIND_POP: begin
          if (count == '0) begin
            status = rpn_alu_pkg::ST_EMPTY;
          end else begin
            top_next    = second;
            second_next = below;
            count_next  = count - CNT_ONE;
          end
        end
        rpn_alu_pkg::KIND_PEEK: begin
          if (count == '0) begin
            status = rpn_alu_pkg::ST_EMPTY;
          end
        end
        rpn_alu_pkg::KIND_ADD, rpn_alu_pkg::KIND_MUL: begin
          if (count == '0) begin
            status = rpn_alu_pkg::ST_EMPTY;
          end else if (count == CNT_ONE) begin
            status = rpn_alu_pkg::ST_ONE;
          end else begin
            top_next    = (kind == rpn_alu_pkg::KIND_ADD) ? sum_sat : prod_sat;
            second_next = below;
            count_next  = count - CNT_ONE;
          end
        end
        default: begin
          status = rpn_alu_pkg::ST_INVALID;
        end
      endcase
    end
  end

  // second spills to the memory on push; the read port follows the new third entry
  assign wr_cnt  = count - CNT_TWO;
  assign rd_cnt  = count_next - CNT_THR;
  assign wr_addr = wr_cnt[AW-1:0];
  assign rd_addr = rd_cnt[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= second;
    end
    // bypass when the spilled entry is the one about to be read
    if (mem_we && (wr_addr == rd_addr)) begin
      below <= second;
    end else begin
      below <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
    top    <= top_next;
    second <= second_next;
  end

  // result word, depth is the low five bits of the count
  assign count_ext = {5'd0, count_next};
  assign res_top   = (count_next == '0) ? '0 : top_next;
  assign res_word  = {7'd0, count_ext[4:0], (count_next != '0), res_top, status};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_word <= skid_valid ? skid_word : res_word;
    end else if (accept) begin
      skid_word <= res_word;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_word;

endmodule

// File: sv/rpn_alu_checker.sv
// port-level checks for the rpn stack calculator, bound to the top level
module rpn_alu_checker #(
  parameter int unsigned STACK_DEPTH = rpn_alu_pkg::STACK_DEPTH_DEF
) (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [rpn_alu_pkg::OUT_DATA_W-1:0] m_tdata
);

  localparam logic SMALL_STACK = (STACK_DEPTH < 32);

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // nothing comes out the cycle after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word right after reset");

  // an empty stack shows a zero top
  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[35] |-> m_tdata[34:3] == 32'd0 && m_tdata[40:36] == 5'd0)
    else $error("empty stack with non-zero top or depth");

  // top_valid follows the depth while the depth fits five bits
  a_valid_depth: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && SMALL_STACK |-> m_tdata[35] == (m_tdata[40:36] != 5'd0))
    else $error("top_valid disagrees with depth");

  // an accepted input word always leaves a result word waiting next cycle
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("input taken without a result word following");

endmodule

bind rpn_stack_alu_core rpn_alu_checker #(.STACK_DEPTH(STACK_DEPTH)) u_rpn_alu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/rpn_stack_alu_checker.sv
// checker for the rpn stack calculator: predicts each result word and compares it
`timescale 1ns / 100ps

module rpn_stack_alu_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  input  logic [rpn_alu_pkg::IN_DATA_W-1:0]  s_tdata,   // push_value[31:0]
  input  logic [rpn_alu_pkg::KIND_W-1:0]     s_tuser,   // kind[2:0]
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // status[2:0], top_value[34:3], top_valid[35], depth[40:36], zero pad [47:41]
  input  logic [rpn_alu_pkg::OUT_DATA_W-1:0] m_tdata,
  output int                                 mismatches,
  output int                                 pending,
  output int                                 n_checked,
  output int                                 n_refused,
  output int                                 n_saturated
);

  typedef struct packed {
    logic [rpn_alu_pkg::STATUS_W-1:0] status;
    logic [rpn_alu_pkg::VALUE_W-1:0]  top;
    logic                             top_valid;
    logic [rpn_alu_pkg::DEPTH_W-1:0]  depth;
  } stack_view_t;

  localparam logic signed [63:0] Q_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Q_LO = 64'shFFFF_FFFF_8000_0000;

  // shadow operand stack
  logic signed [rpn_alu_pkg::VALUE_W-1:0] stack_mem [rpn_alu_pkg::STACK_DEPTH_DEF];
  int unsigned                            stack_cnt;
  stack_view_t                            view_q [$];

  initial begin
    mismatches  = 0;
    pending     = 0;
    n_checked   = 0;
    n_refused   = 0;
    n_saturated = 0;
    stack_cnt   = 0;
  end

  function automatic logic signed [rpn_alu_pkg::VALUE_W-1:0] clamp_q(
    input logic signed [63:0] v);
    if (v > Q_HI) return Q_HI[rpn_alu_pkg::VALUE_W-1:0];
    if (v < Q_LO) return Q_LO[rpn_alu_pkg::VALUE_W-1:0];
    return v[rpn_alu_pkg::VALUE_W-1:0];
  endfunction

  // applies one operation to the shadow stack and returns the state it leaves
  task automatic stack_apply(input logic [rpn_alu_pkg::KIND_W-1:0] kind,
                             input logic signed [rpn_alu_pkg::VALUE_W-1:0] value,
                             output stack_view_t view);
    logic signed [63:0]                     a;
    logic signed [63:0]                     b;
    logic signed [63:0]                     exact;
    logic signed [rpn_alu_pkg::VALUE_W-1:0] r;
    view.status = rpn_alu_pkg::ST_OK;
    case (kind)
      rpn_alu_pkg::KIND_PUSH: begin
        if (stack_cnt == rpn_alu_pkg::STACK_DEPTH_DEF) begin
          view.status = rpn_alu_pkg::ST_FULL;
          n_refused++;
        end else begin
          stack_mem[stack_cnt] = value;
          stack_cnt++;
        end
      end
      rpn_alu_pkg::KIND_POP: begin
        if (stack_cnt == 0) view.status = rpn_alu_pkg::ST_EMPTY;
        else stack_cnt--;
      end
      rpn_alu_pkg::KIND_PEEK: begin
        if (stack_cnt == 0) view.status = rpn_alu_pkg::ST_EMPTY;
      end
      rpn_alu_pkg::KIND_ADD, rpn_alu_pkg::KIND_MUL: begin
        if (stack_cnt == 0) begin
          view.status = rpn_alu_pkg::ST_EMPTY;
        end else if (stack_cnt == 1) begin
          view.status = rpn_alu_pkg::ST_ONE;
        end else begin
          a = stack_mem[stack_cnt-1];
          b = stack_mem[stack_cnt-2];
          // arithmetic shift floors the q32.32 product back to q16.16
          if (kind == rpn_alu_pkg::KIND_ADD) exact = a + b;
          else exact = (b * a) >>> 16;
          r = clamp_q(exact);
          if (exact != r) n_saturated++;
          stack_cnt--;
          stack_mem[stack_cnt-1] = r;
        end
      end
      default: view.status = rpn_alu_pkg::ST_INVALID;
    endcase
    view.top_valid = (stack_cnt != 0);
    if (view.top_valid) view.top = stack_mem[stack_cnt-1];
    else view.top = '0;
    view.depth = stack_cnt[rpn_alu_pkg::DEPTH_W-1:0];
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d: %s expected %0h, got %0h", n_checked, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    stack_view_t want;
    stack_view_t view;
    if (rst) begin
      view_q.delete();
      stack_cnt = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (view_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result word %0h arrived with nothing expected", m_tdata);
        end else begin
          want = view_q.pop_front();
          check_field("status", 32'(want.status), 32'(m_tdata[2:0]));
          check_field("top_value", want.top, m_tdata[34:3]);
          check_field("top_valid", 32'(want.top_valid), 32'(m_tdata[35]));
          check_field("depth", 32'(want.depth), 32'(m_tdata[40:36]));
          check_field("pad", '0, 32'(m_tdata[47:41]));
          n_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        stack_apply(s_tuser, s_tdata, view);
        view_q.push_back(view);
      end
    end
    pending = view_q.size();
  end

endmodule

// File: dv/tb_rpn_stack_alu_core.sv
// testbench top for the rpn stack calculator: stimulus, flow control and verdict
`timescale 1ns / 100ps

module tb_rpn_stack_alu_core;

  typedef logic [rpn_alu_pkg::KIND_W-1:0] kind_t;

  localparam int                              RANDOM_WORDS = 1100;
  localparam int                              IDLE_LIMIT   = 1000;
  localparam kind_t                           KIND_TOP     = 3'd7;   // highest kind, invalid
  localparam logic [rpn_alu_pkg::VALUE_W-1:0] Q_MAX        = 32'h7FFF_FFFF;
  localparam logic [rpn_alu_pkg::VALUE_W-1:0] Q_MIN        = 32'h8000_0000;
  localparam logic [rpn_alu_pkg::VALUE_W-1:0] Q_ONE        = 32'h0001_0000;

  // phases of the random part
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [rpn_alu_pkg::IN_DATA_W-1:0]  s_tdata;   // push_value[31:0]
  logic [rpn_alu_pkg::KIND_W-1:0]     s_tuser;   // kind[2:0]
  logic                               m_tvalid;
  logic                               m_tready;
  logic [rpn_alu_pkg::OUT_DATA_W-1:0] m_tdata;   // status, top_value, top_valid, depth, pad

  int mismatches;
  int pending;
  int n_checked;
  int n_refused;
  int n_saturated;
  int words_sent;
  int idle_cycles;
  bit steady_send;
  bit steady_take;

  rpn_stack_alu_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  rpn_stack_alu_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .mismatches  (mismatches),
    .pending     (pending),
    .n_checked   (n_checked),
    .n_refused   (n_refused),
    .n_saturated (n_saturated)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [rpn_alu_pkg::VALUE_W-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return '0;
      3: return $urandom();
      8: return $urandom_range(0, 1) ? Q_MAX - $urandom_range(0, 255)
                                     : Q_MIN + $urandom_range(0, 255);
      9: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
      // small values around zero, where products stay in range
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  function automatic kind_t pick_kind(input phase_t ph);
    int r;
    r = $urandom_range(0, 99);
    case (ph)
      PH_FILL: begin
        if (r < 70) return rpn_alu_pkg::KIND_PUSH;
        return kind_t'($urandom_range(rpn_alu_pkg::KIND_POP, rpn_alu_pkg::KIND_MUL));
      end
      PH_DRAIN: begin
        if (r < 25) return rpn_alu_pkg::KIND_PUSH;
        if (r < 50) return rpn_alu_pkg::KIND_POP;
        if (r < 70) return rpn_alu_pkg::KIND_ADD;
        if (r < 90) return rpn_alu_pkg::KIND_MUL;
        if (r < 95) return rpn_alu_pkg::KIND_PEEK;
        return kind_t'($urandom_range(rpn_alu_pkg::KIND_MUL + 1, KIND_TOP));
      end
      default: return kind_t'($urandom_range(rpn_alu_pkg::KIND_PUSH, KIND_TOP));
    endcase
  endfunction

  // present one word at the falling edge and hold it until it is taken
  task automatic send_word(input kind_t kind, input logic [rpn_alu_pkg::VALUE_W-1:0] value);
    int gap;
    gap = 0;
    if (!steady_send && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    // push_value is don't-care for other kinds, so keep it random there
    s_tdata  <= (kind == rpn_alu_pkg::KIND_PUSH) ? value : $urandom();
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // receiver: random stalls with quiet stretches where it always takes
  initial begin
    int hold_left;
    hold_left   = 0;
    steady_take = 1'b0;
    m_tready    = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) steady_take = ~steady_take;
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= 1'b1;
        if (!steady_take && $urandom_range(0, 3) == 0) hold_left = pick_gap();
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    phase_t ph;
    int     seg_left;
    kind_t  k;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = rpn_alu_pkg::KIND_PUSH;
    words_sent  = 0;
    idle_cycles = 0;
    steady_send = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: every operation on an empty stack, invalid kinds first
    for (int i = rpn_alu_pkg::KIND_MUL + 1; i <= KIND_TOP; i++) send_word(kind_t'(i), '0);
    send_word(rpn_alu_pkg::KIND_POP, '0);
    send_word(rpn_alu_pkg::KIND_PEEK, '0);
    send_word(rpn_alu_pkg::KIND_ADD, '0);
    send_word(rpn_alu_pkg::KIND_MUL, '0);
    // one element only, then positive add overflow
    send_word(rpn_alu_pkg::KIND_PUSH, Q_MAX);
    send_word(rpn_alu_pkg::KIND_ADD, '0);
    send_word(rpn_alu_pkg::KIND_MUL, '0);
    send_word(rpn_alu_pkg::KIND_PUSH, Q_MAX);
    send_word(rpn_alu_pkg::KIND_ADD, '0);
    // negative add overflow
    send_word(rpn_alu_pkg::KIND_PUSH, Q_MIN);
    send_word(rpn_alu_pkg::KIND_PUSH, Q_MIN);
    send_word(rpn_alu_pkg::KIND_ADD, '0);
    // tiny negative product floors to minus one lsb
    send_word(rpn_alu_pkg::KIND_PUSH, 32'h0000_0003);
    send_word(rpn_alu_pkg::KIND_PUSH, 32'hFFFF_FFFF);
    send_word(rpn_alu_pkg::KIND_MUL, '0);
    // multiply overflow and a plain one-times product
    send_word(rpn_alu_pkg::KIND_PUSH, Q_MAX);
    send_word(rpn_alu_pkg::KIND_PUSH, Q_MAX);
    send_word(rpn_alu_pkg::KIND_MUL, '0);
    send_word(rpn_alu_pkg::KIND_PUSH, Q_ONE);
    send_word(rpn_alu_pkg::KIND_MUL, '0);
    send_word(rpn_alu_pkg::KIND_PEEK, '0);
    send_word(rpn_alu_pkg::KIND_POP, '0);

    // random segments of push-heavy, pop-heavy and mixed traffic
    seg_left = 0;
    ph = PH_MIXED;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (seg_left == 0) begin
        seg_left    = $urandom_range(5, 40);
        ph          = phase_t'($urandom_range(PH_FILL, PH_MIXED));
        steady_send = ($urandom_range(0, 4) == 0);
      end
      seg_left--;
      k = pick_kind(ph);
      send_word(k, pick_operand());
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d words, checked %0d results", words_sent, n_checked);
    $display("%0d pushes refused on a full stack, %0d saturated add or multiply results",
             n_refused, n_saturated);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rpn_alu_pkg.sv
sv/rpn_stack_alu_core.sv
sv/rpn_alu_checker.sv
dv/rpn_stack_alu_checker.sv
dv/tb_rpn_stack_alu_core.sv
